### hw/rtl/u8tr_pkg.sv
package u8tr_pkg;

  localparam logic [7:0]  QMARK        = 8'h3F;
  localparam logic [7:0]  TERM_CHAR    = 8'h00;
  localparam logic [15:0] MAX_OUT_RST  = 16'hFFFF;
  localparam int          FIFO_DEPTH   = 4;
  localparam int          FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } u8tr_seq_t;

  typedef struct packed {
    logic [7:0]  chr;
    logic [15:0] count;
    logic        last;
  } u8tr_res_t;

  typedef struct packed {
    logic [1:0] num;
    u8tr_res_t  res0;
    u8tr_res_t  res1;
  } u8tr_push_t;

  // Three-byte sequences only reach the six Turkish letters.
  function automatic logic [7:0] map_char(input logic [15:0] cp, input logic turk_only);
    logic [7:0] c;
    begin
      case (cp)
        16'h0130: c = 8'hDC;
        16'h0131: c = 8'hDD;
        16'h015E: c = 8'hDE;
        16'h015F: c = 8'hDF;
        16'h011E: c = 8'hDA;
        16'h011F: c = 8'hDB;
        default:  c = QMARK;
      endcase
      if (!turk_only) begin
        case (cp)
          16'h00C4: c = 8'h80;
          16'h00C5: c = 8'h81;
          16'h00C7: c = 8'h82;
          16'h00C9: c = 8'h83;
          16'h00D1: c = 8'h84;
          16'h00D6: c = 8'h85;
          16'h00DC: c = 8'h86;
          16'h00E1: c = 8'h87;
          16'h00E0: c = 8'h88;
          16'h00E2: c = 8'h89;
          16'h00E4: c = 8'h8A;
          16'h00E3: c = 8'h8B;
          16'h00E5: c = 8'h8C;
          16'h00E7: c = 8'h8D;
          16'h00E9: c = 8'h8E;
          16'h00E8: c = 8'h8F;
          16'h00EA: c = 8'h90;
          16'h00EB: c = 8'h91;
          16'h00ED: c = 8'h92;
          16'h00EC: c = 8'h93;
          16'h00EE: c = 8'h94;
          16'h00EF: c = 8'h95;
          16'h00F1: c = 8'h96;
          16'h00F3: c = 8'h97;
          16'h00F2: c = 8'h98;
          16'h00F4: c = 8'h99;
          16'h00F5: c = 8'h9B;
          16'h00F6: c = 8'h9A;
          16'h00FC: c = 8'h9F;
          16'h00FB: c = 8'hAF;
          default:  c = c;
        endcase
      end
      map_char = c;
    end
  endfunction

endpackage

### hw/rtl/u8tr_decode.sv
module u8tr_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               process,
  input  logic [7:0]         item,
  input  logic [15:0]        max_output,
  output u8tr_pkg::u8tr_push_t push
);
  import u8tr_pkg::*;

  logic [1:0]  pend_r, pend_nxt;
  u8tr_seq_t   kind_r, kind_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [15:0] total_r, total_nxt;
  logic        full_r, full_nxt;

  logic [15:0] total_inc;
  logic [15:0] accum_sh;
  logic [15:0] limit;
  logic [1:0]  pend_dec;

  assign total_inc = total_r + 16'd1;
  assign pend_dec  = pend_r - 2'd1;
  assign limit     = (max_output == 16'd0) ? 16'd0 : max_output - 16'd1;

  always_comb begin
    pend_nxt  = pend_r;
    kind_nxt  = kind_r;
    accum_nxt = accum_r;
    total_nxt = total_r;
    full_nxt  = full_r;
    push      = '0;
    accum_sh  = (kind_r != SEQ_FOUR) ? {accum_r[9:0], item[5:0]} : accum_r;
    if (item == TERM_CHAR) begin
      if (pend_r != 2'd0) begin
        push.num  = 2'd2;
        push.res0 = '{chr: QMARK, count: total_inc, last: 1'b0};
        push.res1 = '{chr: TERM_CHAR, count: total_inc, last: 1'b1};
      end else begin
        push.num  = 2'd1;
        push.res0 = '{chr: TERM_CHAR, count: total_r, last: 1'b1};
      end
      pend_nxt  = 2'd0;
      kind_nxt  = SEQ_NONE;
      accum_nxt = 16'd0;
      total_nxt = 16'd0;
      full_nxt  = 1'b0;
    end else if (pend_r != 2'd0) begin
      accum_nxt = accum_sh;
      pend_nxt  = pend_dec;
      if (pend_dec == 2'd0) begin
        push.num = 2'd1;
        case (kind_r)
          SEQ_TWO:   push.res0.chr = map_char(accum_sh, 1'b0);
          SEQ_THREE: push.res0.chr = map_char(accum_sh, 1'b1);
          default:   push.res0.chr = QMARK;
        endcase
        push.res0.count = total_inc;
        push.res0.last  = 1'b0;
        kind_nxt  = SEQ_NONE;
        accum_nxt = 16'd0;
        total_nxt = total_inc;
      end
    end else if (full_r || (total_r >= limit)) begin
      full_nxt = 1'b1;
    end else if (item[7] == 1'b0) begin
      push.num  = 2'd1;
      push.res0 = '{chr: item, count: total_inc, last: 1'b0};
      total_nxt = total_inc;
    end else if ((item & 8'hE0) == 8'hC0) begin
      kind_nxt  = SEQ_TWO;
      pend_nxt  = 2'd1;
      accum_nxt = {11'd0, item[4:0]};
    end else if ((item & 8'hF0) == 8'hE0) begin
      kind_nxt  = SEQ_THREE;
      pend_nxt  = 2'd2;
      accum_nxt = {12'd0, item[3:0]};
    end else if ((item & 8'hF8) == 8'hF0) begin
      kind_nxt  = SEQ_FOUR;
      pend_nxt  = 2'd3;
      accum_nxt = 16'd0;
    end else begin
      push.num  = 2'd1;
      push.res0 = '{chr: QMARK, count: total_inc, last: 1'b0};
      total_nxt = total_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 2'd0;
      kind_r  <= SEQ_NONE;
      accum_r <= 16'd0;
      total_r <= 16'd0;
      full_r  <= 1'b0;
    end else if (process) begin
      pend_r  <= pend_nxt;
      kind_r  <= kind_nxt;
      accum_r <= accum_nxt;
      total_r <= total_nxt;
      full_r  <= full_nxt;
    end
  end

endmodule

### hw/rtl/u8tr_fifo.sv
module u8tr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_en,
  input  u8tr_pkg::u8tr_push_t push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u8tr_pkg::u8tr_res_t  out_res
);
  import u8tr_pkg::*;

  u8tr_res_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]         wp_r, wp_nxt;
  logic [FIFO_AW-1:0]         rp_r, rp_nxt;
  logic [FIFO_AW:0]           cnt_r, cnt_nxt;
  logic [FIFO_AW-1:0]         wp_inc;
  logic [1:0]                 n_push;
  logic                       pop;

  assign room      = (cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;
  assign wp_inc    = wp_r + FIFO_AW'(1);
  assign n_push    = push_en ? push.num : 2'd0;

  always_comb begin
    wp_nxt  = wp_r + FIFO_AW'(n_push);
    rp_nxt  = pop ? rp_r + FIFO_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wp_r] <= push.res0;
    end
    if (n_push == 2'd2) begin
      mem_r[wp_inc] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/utf8_to_turkish_8bit_transcoder.sv
// An accepted word is held in the input byte register; its results then go to the
// result queue. Throughput: one input word per cycle when not stalled; a terminator
// that cuts a sequence short yields two result words, queued together in a
// four-entry queue. Input stalls only while that queue cannot take two more results.
// Reset is synchronous, active low: string state and the queue are cleared and
// max_output returns to 65535.
module utf8_to_turkish_8bit_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [15:0] out_count,
  output logic        out_is_last,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import u8tr_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic [15:0] max_output_r;
  logic        room;
  logic        process;
  logic        accept;
  u8tr_push_t  push;
  u8tr_res_t   out_res;

  assign process  = in_valid_r && room;
  assign in_stall = in_valid_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (process) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      max_output_r <= MAX_OUT_RST;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (cfg_wr_en) begin
        max_output_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_byte;
    end
  end

  u8tr_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .process    (process),
    .item       (in_byte_r),
    .max_output (max_output_r),
    .push       (push)
  );

  u8tr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (process),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte    = out_res.chr;
  assign out_count   = out_res.count;
  assign out_is_last = out_res.last;

`ifndef SYNTHESIS
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("input stalled with no word held");

  a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (process && in_byte_r == TERM_CHAR) |=> out_valid)
    else $error("terminator produced no result");

  a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_last) |-> (out_byte == TERM_CHAR))
    else $error("last word carries a nonzero character");
`endif

endmodule
